// File: hw/rtl/edge_error_lod_selector_unit_macros.svh
// Assertion helpers for the edge error LOD selector back end.
// They use the clock and reset of the module that includes them.
`ifndef EDGE_ERROR_LOD_SELECTOR_UNIT_MACROS_SVH
`define EDGE_ERROR_LOD_SELECTOR_UNIT_MACROS_SVH

// same-cycle implication
`define ELLSU_CHECK(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ellsu check failed");

// next-cycle implication
`define ELLSU_CHECK_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ellsu check failed");

`endif

// File: hw/rtl/ellsu_pkg.sv
package ellsu_pkg;

   localparam logic [31:0] PRECISION_RESET = 32'd1306205;
   localparam logic [31:0] HALF_Q16        = 32'h0000_8000;
   localparam logic [31:0] ERR_SAT         = 32'hFFFF_FFFF;
   localparam logic [1:0]  EDGE_LEFT       = 2'd3;
   localparam int          QDEPTH          = 2;

   // one classified edge: differences in units of 1/64
   typedef struct packed {
      logic [1:0]        edge_idx;
      logic [2:0][30:0]  v;
      logic [2:0][30:0]  w;
   } q_entry_type;

   typedef struct packed {
      logic [31:0]      edge_error;
      logic             edge_high_res;
      logic             strips_valid;
      logic [3:0][1:0]  strip_code;
   } result_type;

   // shared root / divide unit
   typedef struct packed {
      logic        start;
      logic        is_sqrt;
      logic [63:0] num;
      logic [63:0] den;
      logic [31:0] src;
   } iter_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [31:0] result;
   } iter_rsp_type;

   function automatic logic [31:0] mag32(input logic signed [31:0] x);
      logic [31:0] r;
      r = x[31] ? 32'(-x) : 32'(x);
      return r;
   endfunction

endpackage

// File: hw/rtl/ellsu_front.sv
module ellsu_front (
   input  logic signed [31:0]   eye_x,
   input  logic signed [31:0]   eye_y,
   input  logic signed [31:0]   eye_z,
   input  logic signed [31:0]   start_x,
   input  logic signed [31:0]   start_y,
   input  logic signed [31:0]   start_z,
   input  logic signed [31:0]   finish_x,
   input  logic signed [31:0]   finish_y,
   input  logic signed [31:0]   finish_z,
   input  logic [1:0]           edge_index,
   output ellsu_pkg::q_entry_type entry
);

   logic signed [32:0] dv [3];
   logic signed [32:0] dw [3];

   // 33-bit differences, floor divide by 4
   always_comb begin
      dv[0] = 33'(finish_x) - 33'(start_x);
      dv[1] = 33'(finish_y) - 33'(start_y);
      dv[2] = 33'(finish_z) - 33'(start_z);
      dw[0] = 33'(eye_x) - 33'(start_x);
      dw[1] = 33'(eye_y) - 33'(start_y);
      dw[2] = 33'(eye_z) - 33'(start_z);
      entry.edge_idx = edge_index;
      for (int i = 0; i < 3; i++) begin
         entry.v[i] = dv[i][32:2];
         entry.w[i] = dw[i][32:2];
      end
   end

endmodule

// File: hw/rtl/ellsu_fifo.sv
module ellsu_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ellsu_pkg::q_entry_type wdata,
   output logic                   full,
   input  logic                   pop,
   output ellsu_pkg::q_entry_type rdata,
   output logic                   valid
);

   localparam int PtrW = (ellsu_pkg::QDEPTH > 1) ? $clog2(ellsu_pkg::QDEPTH) : 1;
   localparam logic [PtrW-1:0] LastPtr = PtrW'(ellsu_pkg::QDEPTH - 1);
   localparam logic [PtrW:0]   DepthCnt = (PtrW+1)'(ellsu_pkg::QDEPTH);

   ellsu_pkg::q_entry_type mem_ff [ellsu_pkg::QDEPTH];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign full    = (cnt_ff == DepthCnt);
   assign valid   = (cnt_ff != '0);
   assign rdata   = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   // pointer and fill count
   always_comb begin
      wr_in  = do_push ? ((wr_ff == LastPtr) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop  ? ((rd_ff == LastPtr) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/ellsu_iter.sv
module ellsu_iter (
   input  logic                    clock,
   input  logic                    reset,
   input  ellsu_pkg::iter_req_type req,
   output ellsu_pkg::iter_rsp_type rsp
);

   logic        busy_ff, done_ff, sqrt_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] acc_ff, acc_in, den_ff, res_ff, res_in;
   logic [31:0] src_ff;
   logic [63:0] bitv, tb, tshift;
   logic        last;

   assign last = busy_ff && (cnt_ff == 5'd31);
   assign rsp.done   = done_ff;
   assign rsp.busy   = busy_ff;
   assign rsp.result = res_ff[31:0];

   // one root digit or one quotient bit per cycle
   always_comb begin
      bitv   = 64'h4000_0000_0000_0000 >> {cnt_ff, 1'b0};
      tb     = res_ff + bitv;
      tshift = {acc_ff[62:0], src_ff[31]};
      if (sqrt_ff) begin
         if (acc_ff >= tb) begin
            acc_in = acc_ff - tb;
            res_in = (res_ff >> 1) + bitv;
         end else begin
            acc_in = acc_ff;
            res_in = res_ff >> 1;
         end
      end else begin
         if (tshift >= den_ff) begin
            acc_in = tshift - den_ff;
            res_in = {res_ff[62:0], 1'b1};
         end else begin
            acc_in = tshift;
            res_in = {res_ff[62:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last;
         if (req.start) begin
            busy_ff <= 1'b1;
         end else if (last) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         acc_ff  <= req.num;
         den_ff  <= req.den;
         src_ff  <= req.src;
         res_ff  <= '0;
         cnt_ff  <= '0;
         sqrt_ff <= req.is_sqrt;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         res_ff <= res_in;
         src_ff <= {src_ff[30:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

endmodule

// File: hw/rtl/ellsu_back.sv
`include "edge_error_lod_selector_unit_macros.svh"

module ellsu_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  ellsu_pkg::q_entry_type q_data,
   output logic                   q_pop,
   input  logic                   csr_we,
   input  logic [31:0]            csr_data,
   input  logic                   out_pop,
   output logic                   out_valid,
   output ellsu_pkg::result_type  out_data
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_LEN  = 10'b00_0000_0010,
      S_UDIV = 10'b00_0000_0100,
      S_OFF  = 10'b00_0000_1000,
      S_DIST = 10'b00_0001_0000,
      S_SQL  = 10'b00_0010_0000,
      S_SQD  = 10'b00_0100_0000,
      S_EMUL = 10'b00_1000_0000,
      S_EDIV = 10'b01_0000_0000,
      S_DONE = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        ph_ff, ph_in;
   logic [31:0] pf_ff;
   logic [3:0]  bits_ff, bits_in;
   logic        outv_ff, outv_in;
   ellsu_pkg::result_type res_ff;

   logic [1:0]         edge_ff;
   logic signed [30:0] v_ff [3];
   logic signed [30:0] w_ff [3];
   logic signed [30:0] off_ff [3];
   logic signed [30:0] off_in [3];
   logic [61:0]        len2_ff, len2_in;
   logic signed [62:0] dot_ff, dot_in;
   logic [63:0]        d2_ff, d2_in;
   logic [31:0]        u_ff, u_in, len_ff, len_in, dist_ff, dist_in, err_ff, err_in;
   logic [63:0]        prod_ff;
   logic [31:0]        mul_a, mul_b;
   logic [1:0]         lane;
   logic signed [31:0] wd;
   logic               load, res_wr, high_res, iter_wait;
   logic [3:0]         nbits;
   ellsu_pkg::result_type res_in;
   ellsu_pkg::iter_req_type iter_req;
   ellsu_pkg::iter_rsp_type iter_rsp;

   ellsu_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (iter_req),
      .rsp   (iter_rsp)
   );

   assign lane      = (cnt_ff >= 3'd3) ? 2'(cnt_ff - 3'd3) : cnt_ff[1:0];
   assign wd        = 32'(w_ff[lane]) - 32'(off_ff[lane]);
   assign load      = (state_ff == S_IDLE) && q_valid;
   assign q_pop     = load;
   assign res_wr    = (state_ff == S_DONE) && (!outv_ff || out_pop);
   assign out_valid = outv_ff;
   assign out_data  = res_ff;
   assign iter_wait = (state_ff == S_UDIV) || (state_ff == S_SQL) ||
                      (state_ff == S_SQD) || (state_ff == S_EDIV);

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_LEN: begin
            mul_a = ellsu_pkg::mag32(32'(v_ff[lane]));
            mul_b = cnt_ff[2] || (cnt_ff == 3'd3) ? ellsu_pkg::mag32(32'(w_ff[lane]))
                                                  : ellsu_pkg::mag32(32'(v_ff[lane]));
         end
         S_OFF: begin
            mul_a = ellsu_pkg::mag32(32'(v_ff[lane]));
            mul_b = u_ff;
         end
         S_DIST: begin
            mul_a = ellsu_pkg::mag32(wd);
            mul_b = ellsu_pkg::mag32(wd);
         end
         S_EMUL: begin
            mul_a = pf_ff;
            mul_b = len_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // result fields and stored edge bits
   always_comb begin
      high_res = (err_ff > ellsu_pkg::HALF_Q16);
      nbits    = bits_ff;
      nbits[edge_ff] = high_res;
      res_in.edge_error    = err_ff;
      res_in.edge_high_res = high_res;
      res_in.strips_valid  = (edge_ff == ellsu_pkg::EDGE_LEFT);
      for (int i = 0; i < 4; i++) begin
         res_in.strip_code[i] = res_in.strips_valid ?
                                {nbits[(i + 3) % 4], nbits[i]} : 2'd0;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ph_in    = ph_ff;
      len2_in  = len2_ff;
      dot_in   = dot_ff;
      d2_in    = d2_ff;
      u_in     = u_ff;
      len_in   = len_ff;
      dist_in  = dist_ff;
      err_in   = err_ff;
      off_in   = off_ff;
      bits_in  = bits_ff;
      outv_in  = outv_ff && !out_pop;
      iter_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               len2_in  = '0;
               dot_in   = '0;
               cnt_in   = '0;
               ph_in    = 1'b0;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (cnt_ff < 3'd3) begin
                  len2_in = len2_ff + prod_ff[61:0];
               end else if (v_ff[lane][30] ^ w_ff[lane][30]) begin
                  dot_in = dot_ff - 63'(prod_ff[61:0]);
               end else begin
                  dot_in = dot_ff + 63'(prod_ff[61:0]);
               end
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd5) begin
                  cnt_in = '0;
                  d2_in  = '0;
                  if (len2_ff == '0 || dot_in[62] || dot_in == '0) begin
                     for (int i = 0; i < 3; i++) off_in[i] = '0;
                     state_in = S_DIST;
                  end else if (dot_in[61:0] >= len2_ff) begin
                     off_in   = v_ff;
                     state_in = S_DIST;
                  end else begin
                     iter_req.start = 1'b1;
                     iter_req.num   = {2'b00, dot_in[61:0]};
                     iter_req.den   = {2'b00, len2_ff};
                     state_in       = S_UDIV;
                  end
               end
            end
         end
         S_UDIV: begin
            if (iter_rsp.done) begin
               u_in     = iter_rsp.result;
               state_in = S_OFF;
            end
         end
         S_OFF: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               off_in[lane] = v_ff[lane][30] ? -31'(prod_ff[61:32]) : 31'(prod_ff[61:32]);
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd2) begin
                  cnt_in   = '0;
                  state_in = S_DIST;
               end
            end
         end
         S_DIST: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               d2_in  = d2_ff + prod_ff;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff == 3'd2) begin
                  cnt_in           = '0;
                  iter_req.start   = 1'b1;
                  iter_req.is_sqrt = 1'b1;
                  iter_req.num     = {2'b00, len2_ff};
                  state_in         = S_SQL;
               end
            end
         end
         S_SQL: begin
            if (iter_rsp.done) begin
               len_in           = iter_rsp.result;
               iter_req.start   = 1'b1;
               iter_req.is_sqrt = 1'b1;
               iter_req.num     = d2_ff;
               state_in         = S_SQD;
            end
         end
         S_SQD: begin
            if (iter_rsp.done) begin
               dist_in = iter_rsp.result;
               if (iter_rsp.result == '0) begin
                  err_in   = ellsu_pkg::ERR_SAT;
                  state_in = S_DONE;
               end else begin
                  ph_in    = 1'b0;
                  state_in = S_EMUL;
               end
            end
         end
         S_EMUL: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (prod_ff[63:32] >= dist_ff) begin
                  err_in   = ellsu_pkg::ERR_SAT;
                  state_in = S_DONE;
               end else begin
                  iter_req.start = 1'b1;
                  iter_req.num   = {32'd0, prod_ff[63:32]};
                  iter_req.den   = {32'd0, dist_ff};
                  iter_req.src   = prod_ff[31:0];
                  state_in       = S_EDIV;
               end
            end
         end
         S_EDIV: begin
            if (iter_rsp.done) begin
               err_in   = iter_rsp.result;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_wr) begin
               bits_in  = nbits;
               outv_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ph_ff    <= 1'b0;
         pf_ff    <= ellsu_pkg::PRECISION_RESET;
         bits_ff  <= '0;
         outv_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         bits_ff  <= bits_in;
         outv_ff  <= outv_in;
         if (csr_we) begin
            pf_ff <= csr_data;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      cnt_ff  <= cnt_in;
      len2_ff <= len2_in;
      dot_ff  <= dot_in;
      d2_ff   <= d2_in;
      u_ff    <= u_in;
      len_ff  <= len_in;
      dist_ff <= dist_in;
      err_ff  <= err_in;
      off_ff  <= off_in;
      if (load) begin
         edge_ff <= q_data.edge_idx;
         for (int i = 0; i < 3; i++) begin
            v_ff[i] <= q_data.v[i];
            w_ff[i] <= q_data.w[i];
         end
      end
      if (res_wr) begin
         res_ff <= res_in;
      end
   end

   `ELLSU_CHECK(a_iter_done_wait, iter_rsp.done, iter_wait)
   `ELLSU_CHECK(a_iter_start_free, iter_req.start, !iter_rsp.busy)
   `ELLSU_CHECK_NEXT(a_load_to_len, load, state_ff == S_LEN && cnt_ff == 3'd0)
   `ELLSU_CHECK_NEXT(a_bit_kept, res_wr, bits_ff[$past(edge_ff)] == $past(high_res) && outv_ff)

endmodule

// File: hw/rtl/edge_error_lod_selector_unit.sv
// Edge screen-space error and LOD selector.
// Input queue side: drive the edge index, eye point and the edge's start and
// finish corners (signed Q24.8) with req_push; a beat is taken when req_push is
// high and req_full is low. Result queue side: while rsp_empty is low the
// oldest result sits on the rsp_ ports (error as unsigned Q16.16, the high
// resolution bit, and on an edge 3 beat the four strip codes); rsp_pop takes it.
// csr_valid with csr_ready writes precision_factor; csr_ready is always high.
// A two-entry queue sits between the classifying front and the sequenced back
// end, so the queue takes edges while the back end works or the receiver
// stalls. In the back end each edge makes up to thirteen multiplies on the
// shared multiplier, then up to four runs on the shared root/divide unit
// (closest point parameter, two roots, the error division). With rsp_pop held
// low one result is held, one edge waits finished in the back end and two more
// wait in the queue.
// Reset (synchronous) empties both queues, clears the stored per-edge bits and
// loads precision_factor with its default, about 19.93.
module edge_error_lod_selector_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_edge_index,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_start_x,
   input  logic signed [31:0] req_start_y,
   input  logic signed [31:0] req_start_z,
   input  logic signed [31:0] req_finish_x,
   input  logic signed [31:0] req_finish_y,
   input  logic signed [31:0] req_finish_z,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_edge_error,
   output logic               rsp_edge_high_res,
   output logic               rsp_strips_valid,
   output logic [1:0]         rsp_strip_code_0,
   output logic [1:0]         rsp_strip_code_1,
   output logic [1:0]         rsp_strip_code_2,
   output logic [1:0]         rsp_strip_code_3,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_precision_factor
);

   ellsu_pkg::q_entry_type front_entry, q_head;
   ellsu_pkg::result_type  res;
   logic q_valid, q_pop, out_valid;

   assign csr_ready = 1'b1;

   ellsu_front u_front (
      .eye_x      (req_eye_x),
      .eye_y      (req_eye_y),
      .eye_z      (req_eye_z),
      .start_x    (req_start_x),
      .start_y    (req_start_y),
      .start_z    (req_start_z),
      .finish_x   (req_finish_x),
      .finish_y   (req_finish_y),
      .finish_z   (req_finish_z),
      .edge_index (req_edge_index),
      .entry      (front_entry)
   );

   ellsu_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_entry),
      .full  (req_full),
      .pop   (q_pop),
      .rdata (q_head),
      .valid (q_valid)
   );

   ellsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_precision_factor),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_data  (res)
   );

   // result beat
   assign rsp_empty         = !out_valid;
   assign rsp_edge_error    = res.edge_error;
   assign rsp_edge_high_res = res.edge_high_res;
   assign rsp_strips_valid  = res.strips_valid;
   assign rsp_strip_code_0  = res.strip_code[0];
   assign rsp_strip_code_1  = res.strip_code[1];
   assign rsp_strip_code_2  = res.strip_code[2];
   assign rsp_strip_code_3  = res.strip_code[3];

endmodule

// File: tb/sv/tb_edge_error_lod_selector_unit.sv
`timescale 1ns / 1ps

module tb_edge_error_lod_selector_unit;

   // one edge beat as offered on the req_ ports
   typedef struct packed {
      logic [1:0]       edge_idx;
      logic [2:0][31:0] eye;
      logic [2:0][31:0] start;
      logic [2:0][31:0] finish;
   } edge_beat_type;

   // expected edge errors and per-edge resolution bits
   class edge_error_board_type;
      ellsu_pkg::result_type pending_results[$];
      logic [31:0] precision;
      logic [3:0]  res_bits;
      int          mismatches;
      int          checked;

      function new();
         precision  = ellsu_pkg::PRECISION_RESET;
         res_bits   = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function logic [63:0] floor_sqrt(logic [63:0] val);
         logic [63:0] root;
         logic [63:0] bitpos;
         root   = 0;
         bitpos = 64'd1 << 62;
         while (bitpos > val) bitpos = bitpos >> 2;
         while (bitpos != 0) begin
            if (val >= root + bitpos) begin
               val  = val - (root + bitpos);
               root = (root >> 1) + bitpos;
            end else begin
               root = root >> 1;
            end
            bitpos = bitpos >> 2;
         end
         return root;
      endfunction

      function logic [63:0] magnitude(logic signed [63:0] x);
         return x < 0 ? 64'(-x) : 64'(x);
      endfunction

      // predict the result of one accepted edge beat
      function void note_edge(edge_beat_type b);
         logic signed [32:0] diff;
         logic signed [63:0] v[3];
         logic signed [63:0] w[3];
         logic signed [63:0] off[3];
         logic signed [63:0] dot;
         logic [63:0]        len2;
         logic [63:0]        d2;
         logic [63:0]        m;
         logic [63:0]        len;
         logic [63:0]        eye_dist;
         logic [63:0]        err;
         logic [95:0]        num;
         logic [63:0]        u;
         ellsu_pkg::result_type r;
         len2 = 0;
         d2   = 0;
         dot  = 0;
         for (int i = 0; i < 3; i++) begin
            diff = $signed({b.finish[i][31], b.finish[i]}) - $signed({b.start[i][31], b.start[i]});
            v[i] = diff >>> 2;
            diff = $signed({b.eye[i][31], b.eye[i]}) - $signed({b.start[i][31], b.start[i]});
            w[i] = diff >>> 2;
         end
         for (int i = 0; i < 3; i++) begin
            m    = magnitude(v[i]);
            len2 = len2 + m * m;
            dot  = dot + v[i] * w[i];
         end
         // closest point on the edge, as offset from start
         if (len2 == 0 || dot <= 0) begin
            for (int i = 0; i < 3; i++) off[i] = 0;
         end else if ($unsigned(dot) >= len2) begin
            for (int i = 0; i < 3; i++) off[i] = v[i];
         end else begin
            num = {dot, 32'b0};
            u   = 64'(num / {32'b0, len2});
            for (int i = 0; i < 3; i++) begin
               m      = (magnitude(v[i]) * u) >> 32;
               off[i] = v[i] < 0 ? -$signed(m) : $signed(m);
            end
         end
         for (int i = 0; i < 3; i++) begin
            m  = magnitude(w[i] - off[i]);
            d2 = d2 + m * m;
         end
         len      = floor_sqrt(len2);
         eye_dist = floor_sqrt(d2);
         if (eye_dist == 0) begin
            err = {32'b0, ellsu_pkg::ERR_SAT};
         end else begin
            err = ({32'b0, precision} * len) / eye_dist;
            if (err > {32'b0, ellsu_pkg::ERR_SAT}) err = {32'b0, ellsu_pkg::ERR_SAT};
         end
         r = '0;
         r.edge_error    = err[31:0];
         r.edge_high_res = err[31:0] > ellsu_pkg::HALF_Q16;
         res_bits[b.edge_idx] = r.edge_high_res;
         if (b.edge_idx == ellsu_pkg::EDGE_LEFT) begin
            r.strips_valid = 1'b1;
            for (int i = 0; i < 4; i++)
               r.strip_code[i] = {res_bits[(i + 3) % 4], res_bits[i]};
         end
         pending_results = {pending_results, r};
      endfunction

      // compare one popped result with the oldest prediction
      function void check_result(ellsu_pkg::result_type got);
         ellsu_pkg::result_type exp_r;
         checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result with none expected: %p", got);
            return;
         end
         exp_r = pending_results.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d: exp err=%h hi=%b sv=%b codes=%h,", checked,
                        exp_r.edge_error, exp_r.edge_high_res, exp_r.strips_valid,
                        exp_r.strip_code);
               $display("       got err=%h hi=%b sv=%b codes=%h", got.edge_error,
                        got.edge_high_res, got.strips_valid, got.strip_code);
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   edge_beat_type beat;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [31:0] rsp_edge_error;
   logic        rsp_edge_high_res;
   logic        rsp_strips_valid;
   logic [1:0]  rsp_strip_code_0, rsp_strip_code_1, rsp_strip_code_2, rsp_strip_code_3;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_precision_factor;

   edge_error_lod_selector_unit uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_edge_index(beat.edge_idx),
      .req_eye_x(beat.eye[0]), .req_eye_y(beat.eye[1]), .req_eye_z(beat.eye[2]),
      .req_start_x(beat.start[0]), .req_start_y(beat.start[1]), .req_start_z(beat.start[2]),
      .req_finish_x(beat.finish[0]), .req_finish_y(beat.finish[1]),
      .req_finish_z(beat.finish[2]),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_edge_error(rsp_edge_error), .rsp_edge_high_res(rsp_edge_high_res),
      .rsp_strips_valid(rsp_strips_valid),
      .rsp_strip_code_0(rsp_strip_code_0), .rsp_strip_code_1(rsp_strip_code_1),
      .rsp_strip_code_2(rsp_strip_code_2), .rsp_strip_code_3(rsp_strip_code_3),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_precision_factor(csr_precision_factor)
   );

   edge_error_board_type board = new();
   int send_idle_pct = 33;
   int recv_idle_pct = 46;
   int edges_sent    = 0;
   int cfg_writes    = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #10ms;
      $display("Simulation FAILED");
      $finish;
   end

   // receiver: random pop, one long hold-off after 60 beats
   initial begin
      ellsu_pkg::result_type got;
      int         hold;
      bit         held;
      rsp_pop = 1'b0;
      hold    = 0;
      held    = 0;
      forever begin
         @(negedge clock);
         if (!held && board.checked == 60) begin
            held = 1;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.edge_error    = rsp_edge_error;
            got.edge_high_res = rsp_edge_high_res;
            got.strips_valid  = rsp_strips_valid;
            got.strip_code    = {rsp_strip_code_3, rsp_strip_code_2,
                                 rsp_strip_code_1, rsp_strip_code_0};
            board.check_result(got);
         end
      end
   end

   // offer one edge beat, with a random gap before it
   task automatic send_edge(edge_beat_type b);
      if ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
         repeat ($urandom_range(4)) @(negedge clock);
      end
      @(negedge clock);
      req_push <= 1'b1;
      beat     <= b;
      do @(posedge clock); while (req_full);
      board.note_edge(b);
      edges_sent++;
   endtask

   task automatic write_precision(logic [31:0] val);
      @(negedge clock);
      req_push             <= 1'b0;
      csr_valid            <= 1'b1;
      csr_precision_factor <= val;
      do @(posedge clock); while (!csr_ready);
      board.precision = val;
      cfg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait until every predicted result has been popped, then let the back end settle
   task automatic drain();
      @(negedge clock);
      req_push <= 1'b0;
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(8000)) - 4000);
         default: return 32'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   // random edge: mostly small well-formed geometry, some full-range noise
   function automatic edge_beat_type random_edge(logic [1:0] idx);
      edge_beat_type b;
      int mode, kind;
      logic [31:0] t;
      mode = $urandom_range(9) < 2 ? 0 : $urandom_range(2, 1);
      b.edge_idx = idx;
      for (int i = 0; i < 3; i++) begin
         b.eye[i]    = rand_coord(mode);
         b.start[i]  = rand_coord(mode);
         b.finish[i] = rand_coord(mode);
      end
      kind = $urandom_range(19);
      case (kind)
         0: b.finish = b.start;        // zero-length edge
         1: b.eye    = b.start;        // eye on the start corner
         2: b.eye    = b.finish;
         3: begin                      // eye near the middle of the edge
            for (int i = 0; i < 3; i++) begin
               t = b.finish[i] - b.start[i];
               b.eye[i] = b.start[i] + $signed(t) / 2;
            end
         end
         default: ;
      endcase
      return b;
   endfunction

   function automatic edge_beat_type make_edge(logic [1:0] idx, logic [31:0] ex,
                                               logic [31:0] ey, logic [31:0] ez,
                                               logic [31:0] sx, logic [31:0] sy,
                                               logic [31:0] sz, logic [31:0] fx,
                                               logic [31:0] fy, logic [31:0] fz);
      edge_beat_type b;
      b.edge_idx = idx;
      b.eye      = {ez, ey, ex};
      b.start    = {sz, sy, sx};
      b.finish   = {fz, fy, fx};
      return b;
   endfunction

   localparam logic [31:0] SMAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SMIN = 32'h8000_0000;
   localparam logic [1:0]  LEFT = ellsu_pkg::EDGE_LEFT;

   initial begin
      logic [1:0] idx;
      int n;
      reset                = 1'b1;
      req_push             = 1'b0;
      beat                 = '0;
      csr_valid            = 1'b0;
      csr_precision_factor = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed edges at the default precision
      send_edge(make_edge(LEFT, 0, 0, 0, 0, 0, 0, 0, 0, 0));    // strips before any other edge
      send_edge(make_edge(2'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0));    // zero length, zero distance
      send_edge(make_edge(2'd1, 1000, 0, 0, 0, 0, 0, 0, 0, 0)); // zero length, nonzero distance
      send_edge(make_edge(2'd2, 0, 0, 0, 0, 0, 0, 4096, 0, 0)); // eye on start corner
      send_edge(make_edge(LEFT, 4096, 0, 0, 0, 0, 0, 4096, 0, 0));
      send_edge(make_edge(2'd0, -500, 300, 0, 0, 0, 0, 4096, 0, 0));  // eye behind start
      send_edge(make_edge(2'd1, 9000, 300, 7, 0, 0, 0, 4096, 0, 0));  // eye past finish
      send_edge(make_edge(2'd2, 2000, 50000, 100, 0, 0, 0, 4096, 0, 0));
      send_edge(make_edge(LEFT, 2000, 1, 0, 0, 0, 0, 4096, 0, 0));
      send_edge(make_edge(2'd0, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX));
      send_edge(make_edge(2'd1, SMIN, SMAX, SMIN, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN));
      send_edge(make_edge(2'd2, 0, 0, 0, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX));
      send_edge(make_edge(LEFT, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
      send_edge(make_edge(2'd0, 3, 7, -5, -1, -2, -3, 2, 1, 3));     // tiny edge, rounding
      send_edge(make_edge(LEFT, 1, 0, 0, -1, 0, 0, 2, 0, 0));
      drain();

      // random part over several precision settings and idling mixes
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_precision(32'h0);
            1: write_precision(32'hFFFF_FFFF);
            2: write_precision($urandom());
            3: write_precision($urandom_range(32'h0010_0000));
            default: write_precision(ellsu_pkg::PRECISION_RESET);
         endcase
         if (phase == 2) begin
            send_idle_pct = 46;
            recv_idle_pct = 33;
         end else if (phase == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         n = 0;
         while (n < 180) begin
            if ($urandom_range(9) < 8) begin
               for (int e = 0; e < 4; e++) begin
                  send_edge(random_edge(2'(e)));
                  n++;
               end
            end else begin
               idx = 2'($urandom_range(3));
               send_edge(random_edge(idx));
               n++;
            end
         end
         drain();
      end

      $display("Covered %0d edge beats, %0d precision writes, zero-length, zero-distance",
               edges_sent, cfg_writes);
      $display("and full-range edges with random gaps and a long result hold-off.");
      if (board.mismatches == 0 && board.pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending_results.size());
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
